@@ rtl/detection_top1_box_select_core_defines.svh @@
// Assertion macros shared by the box select RTL
`ifndef DETECTION_TOP1_BOX_SELECT_CORE_DEFINES_SVH
`define DETECTION_TOP1_BOX_SELECT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DTBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box select check failed");

// next-cycle implication, clocked on clk, off during reset
`define DTBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box select check failed");

`endif

@@ rtl/dtbs_pkg.sv @@
// Types, constants and helper functions for the box select block
package dtbs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DIM_W       = 13;
	localparam int PIX_W       = 12;
	localparam int TWICE_W     = 19;
	localparam int PROD_W      = 36;
	localparam int FRAC_SHIFT  = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd4;

	typedef struct packed {
		logic [15:0] ctr_x;
		logic [15:0] ctr_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
		logic [15:0] class_score;
		logic        last_class;
		logic        last_anchor;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [PIX_W-1:0] rect_x;
		logic [PIX_W-1:0] rect_y;
		logic [PIX_W-1:0] rect_width;
		logic [PIX_W-1:0] rect_height;
	} result_t;

	typedef struct packed {
		logic [15:0] score;
		logic [15:0] ctr_x;
		logic [15:0] ctr_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
		logic        last_anchor;
	} cand_t;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [15:0]      scale_x;
		logic [15:0]      scale_y;
		logic [15:0]      score_threshold;
	} cfg_t;

	function automatic logic [PIX_W-1:0] clamp_bound(input logic [DIM_W-1:0] dim);
		logic [PIX_W-1:0] b;
		b = '0;
		if (dim == '0) begin
			b = '0;
		end else if (dim > DIM_W'(4096)) begin
			b = '1;
		end else begin
			b = PIX_W'(dim - DIM_W'(1));
		end
		return b;
	endfunction

	function automatic logic [PIX_W-1:0] corner_pix(input logic signed [PROD_W-1:0] prod,
			input logic [PIX_W-1:0] bound);
		logic [PROD_W-FRAC_SHIFT-1:0] pix;
		logic [PIX_W-1:0]             r;
		pix = prod[PROD_W-1:FRAC_SHIFT];
		r = '0;
		if (prod[PROD_W-1] || prod == '0) begin
			r = '0;
		end else if (pix > (PROD_W-FRAC_SHIFT)'(bound)) begin
			r = bound;
		end else begin
			r = pix[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/dtbs_front.sv @@
// Front part: per-anchor maximum class score, emits one candidate per anchor
module dtbs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  dtbs_pkg::item_t item,
	input  logic            queue_full,
	output logic            push,
	output dtbs_pkg::cand_t cand
);

	logic [15:0] anchor_max_q;
	logic [15:0] score_max;
	logic        accept;

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;
	assign score_max  = (item.class_score > anchor_max_q) ? item.class_score : anchor_max_q;
	assign push       = accept && item.last_class;

	always_comb begin
		cand.score       = score_max;
		cand.ctr_x       = item.ctr_x;
		cand.ctr_y       = item.ctr_y;
		cand.box_w       = item.box_w;
		cand.box_h       = item.box_h;
		cand.last_anchor = item.last_anchor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_max_q <= '0;
		end else if (accept) begin
			anchor_max_q <= item.last_class ? '0 : score_max;
		end
	end

endmodule

@@ rtl/dtbs_queue.sv @@
// Short candidate queue between front and back parts
`include "detection_top1_box_select_core_defines.svh"
module dtbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dtbs_pkg::cand_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output dtbs_pkg::cand_t head
);

	dtbs_pkg::cand_t                   entry_q [dtbs_pkg::QUEUE_DEPTH];
	logic [dtbs_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [dtbs_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [dtbs_pkg::QUEUE_PTR_W:0]    count_q;

	assign full  = (count_q == (dtbs_pkg::QUEUE_PTR_W+1)'(dtbs_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`DTBS_ASSERT_IMP(a_no_push_full, push, !full)
	`DTBS_ASSERT_IMP(a_no_pop_empty, pop, !empty)

endmodule

@@ rtl/dtbs_back.sv @@
// Back part: best-score tracking, corner scaling pipeline, result register
`include "detection_top1_box_select_core_defines.svh"
module dtbs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dtbs_pkg::cfg_t    cfg,
	input  logic              empty,
	input  dtbs_pkg::cand_t   head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output dtbs_pkg::result_t result
);

	localparam int PW = dtbs_pkg::PIX_W;
	localparam int TW = dtbs_pkg::TWICE_W;
	localparam int MW = dtbs_pkg::PROD_W;

	logic        adv;
	logic        win;
	logic        best_valid_q;
	logic [15:0] best_score_q;

	logic                 v_s1, win_s1, last_s1, found_s1;
	logic signed [TW-1:0] tx1_s1, tx2_s1, ty1_s1, ty2_s1;
	logic                 v_s2, win_s2, last_s2, found_s2;
	logic signed [MW-1:0] px1_s2, px2_s2, py1_s2, py2_s2;
	logic                 v_s3, win_s3, last_s3, found_s3;
	logic [PW-1:0]        x1_s3, x2_s3, y1_s3, y2_s3;

	logic [PW-1:0] best_left_q, best_top_q, best_span_x_q, best_span_y_q;
	logic [PW-1:0] bound_x, bound_y;
	logic [PW-1:0] left_sel, top_sel, span_x_sel, span_y_sel;
	logic          result_valid_q;
	dtbs_pkg::result_t result_q;

	assign adv = !result_valid_q || result_ready;
	assign pop = adv && !empty;
	assign win = (head.score > cfg.score_threshold) &&
		(!best_valid_q || head.score > best_score_q);

	assign bound_x = dtbs_pkg::clamp_bound(cfg.image_width);
	assign bound_y = dtbs_pkg::clamp_bound(cfg.image_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_score_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			if (pop) begin
				if (head.last_anchor) begin
					best_valid_q <= 1'b0;
					best_score_q <= '0;
				end else if (win) begin
					best_valid_q <= 1'b1;
					best_score_q <= head.score;
				end
			end
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			result_valid_q <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s1   <= win;
			last_s1  <= head.last_anchor;
			found_s1 <= best_valid_q || win;
			tx1_s1   <= $signed({2'b00, head.ctr_x, 1'b0}) - $signed({3'b000, head.box_w});
			tx2_s1   <= $signed({2'b00, head.ctr_x, 1'b0}) + $signed({3'b000, head.box_w});
			ty1_s1   <= $signed({2'b00, head.ctr_y, 1'b0}) - $signed({3'b000, head.box_h});
			ty2_s1   <= $signed({2'b00, head.ctr_y, 1'b0}) + $signed({3'b000, head.box_h});

			win_s2   <= win_s1;
			last_s2  <= last_s1;
			found_s2 <= found_s1;
			px1_s2   <= tx1_s1 * $signed({1'b0, cfg.scale_x});
			px2_s2   <= tx2_s1 * $signed({1'b0, cfg.scale_x});
			py1_s2   <= ty1_s1 * $signed({1'b0, cfg.scale_y});
			py2_s2   <= ty2_s1 * $signed({1'b0, cfg.scale_y});

			win_s3   <= win_s2;
			last_s3  <= last_s2;
			found_s3 <= found_s2;
			x1_s3    <= dtbs_pkg::corner_pix(px1_s2, bound_x);
			x2_s3    <= dtbs_pkg::corner_pix(px2_s2, bound_x);
			y1_s3    <= dtbs_pkg::corner_pix(py1_s2, bound_y);
			y2_s3    <= dtbs_pkg::corner_pix(py2_s2, bound_y);

			if (v_s3 && win_s3) begin
				best_left_q   <= left_sel;
				best_top_q    <= top_sel;
				best_span_x_q <= span_x_sel;
				best_span_y_q <= span_y_sel;
			end
			if (v_s3 && last_s3) begin
				result_q.found       <= found_s3;
				result_q.rect_x      <= found_s3 ? left_sel : '0;
				result_q.rect_y      <= found_s3 ? top_sel : '0;
				result_q.rect_width  <= found_s3 ? span_x_sel : '0;
				result_q.rect_height <= found_s3 ? span_y_sel : '0;
			end
		end
	end

	always_comb begin
		if (win_s3) begin
			left_sel   = x1_s3;
			top_sel    = y1_s3;
			span_x_sel = x2_s3 - x1_s3;
			span_y_sel = y2_s3 - y1_s3;
		end else begin
			left_sel   = best_left_q;
			top_sel    = best_top_q;
			span_x_sel = best_span_x_q;
			span_y_sel = best_span_y_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`DTBS_ASSERT_IMP(a_empty_rect_zero, result_valid_q && !result_q.found, (result_q.rect_x == '0) && (result_q.rect_y == '0) && (result_q.rect_width == '0) && (result_q.rect_height == '0))
	`DTBS_ASSERT_IMP(a_score_needs_valid, !best_valid_q, best_score_q == '0)
	`DTBS_ASSERT_NXT(a_frame_clears, pop && head.last_anchor, !best_valid_q)
	`DTBS_ASSERT_IMP(a_win_implies_found, v_s3 && win_s3, found_s3)

endmodule

@@ rtl/detection_top1_box_select_core.sv @@
// Top level of the top-1 detection box select block
// Usage:
//   item channel (item_valid/item_ready/item) takes one class score per transfer,
//   anchor by anchor; last_class marks an anchor's final class, last_anchor marks
//   every item of the frame's final anchor.
//   result channel (result_valid/result_ready/result) gives one transfer per frame,
//   on the item with both flags set: the best box in image pixels, or found = 0.
//   cfg_write/cfg_index/cfg_data write image size, scales and score threshold;
//   write only while the block is idle.
// Throughput: one item per cycle while the queue is not full.
// Result path: the frame's last candidate is written into the queue, then
//   passes the back-end stages (corner sums, scale multiply, clamp, result
//   register), and result_valid rises from the result register.
// Reset: clears the per-anchor maximum, the best score, the queue and the
//   pipeline; registers return to 640 x 640, scale 1.0, threshold 6554.
// Stall: a held result freezes the back end; the four-entry queue keeps taking
//   anchors until it fills, then item_ready drops.
module detection_top1_box_select_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  dtbs_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output dtbs_pkg::result_t                 result,
	input  logic                              cfg_write,
	input  logic [dtbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dtbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dtbs_pkg::cfg_t  cfg_q;
	dtbs_pkg::cand_t cand;
	dtbs_pkg::cand_t head;
	logic            push, pop, full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= dtbs_pkg::DIM_W'(640);
			cfg_q.image_height    <= dtbs_pkg::DIM_W'(640);
			cfg_q.scale_x         <= 16'd4096;
			cfg_q.scale_y         <= 16'd4096;
			cfg_q.score_threshold <= 16'd6554;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dtbs_pkg::CFG_IMAGE_WIDTH:     cfg_q.image_width <= cfg_data[dtbs_pkg::DIM_W-1:0];
				dtbs_pkg::CFG_IMAGE_HEIGHT:    cfg_q.image_height <= cfg_data[dtbs_pkg::DIM_W-1:0];
				dtbs_pkg::CFG_SCALE_X:         cfg_q.scale_x <= cfg_data;
				dtbs_pkg::CFG_SCALE_Y:         cfg_q.scale_y <= cfg_data;
				dtbs_pkg::CFG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data;
				default:                       cfg_q <= cfg_q;
			endcase
		end
	end

	dtbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (full),
		.push       (push),
		.cand       (cand)
	);

	dtbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cand),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	dtbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
